@@ src/sfgs_pkg.sv @@
// Package: shared constants, event codes and controller/datapath types.
`default_nettype none
package sfgs_pkg;

  localparam int GROUP_SIZE     = 6;
  localparam int DEBOUNCE_SLOTS = 3;

  localparam int BITS_W     = 7;
  localparam int DATA_W     = 64;
  localparam int UPPER_W    = 32;
  localparam int IDX_W      = 4;
  localparam int SLOT_W     = 2;
  localparam int EV_W       = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [BITS_W-1:0] EXP_BITS_RST = 7'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_UPPER  = 1'd1;

  localparam logic [EV_W-1:0] EV_EMPTY     = 4'd0;
  localparam logic [EV_W-1:0] EV_SHORT     = 4'd1;
  localparam logic [EV_W-1:0] EV_LONG      = 4'd2;
  localparam logic [EV_W-1:0] EV_IGNORED   = 4'd3;
  localparam logic [EV_W-1:0] EV_STARTED   = 4'd4;
  localparam logic [EV_W-1:0] EV_STORED    = 4'd5;
  localparam logic [EV_W-1:0] EV_CHKFAIL   = 4'd6;
  localparam logic [EV_W-1:0] EV_AWAITING  = 4'd7;
  localparam logic [EV_W-1:0] EV_PUBLISHED = 4'd8;
  localparam logic [EV_W-1:0] EV_FRAME     = 4'd9;

  typedef struct packed {
    logic [DATA_W-1:0] miso;
    logic [DATA_W-1:0] mosi;
  } frame_t;

  typedef struct packed {
    logic              cap;
    logic              grp_we;
    logic              grp_re;
    logic              hist_we;
    logic              hist_re;
    logic [IDX_W-1:0]  idx;
    logic [SLOT_W-1:0] slot;
    logic              out_load;
    logic [EV_W-1:0]   ev;
    logic              drop;
    logic              last;
    logic              frame_sel;
  } cmd_t;

  typedef struct packed {
    logic wrong_len;
    logic empty;
    logic short_len;
    logic marker;
    logic rep_ok;
    logic mismatch;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ src/sfgs_in_if.sv @@
// Input channel interface: one sniffed SPI transfer per beat.
`default_nettype none
interface sfgs_in_if;
  logic                              valid;
  logic                              ready;
  logic [sfgs_pkg::BITS_W-1:0]       transfer_bits;
  logic [sfgs_pkg::DATA_W-1:0]       frame_miso;
  logic [sfgs_pkg::DATA_W-1:0]       frame_mosi;

  modport source (output valid, output transfer_bits, output frame_miso,
                  output frame_mosi, input ready);
  modport sink   (input valid, input transfer_bits, input frame_miso,
                  input frame_mosi, output ready);
endinterface
`default_nettype wire

@@ src/sfgs_out_if.sv @@
// Result channel interface: one status or published frame per beat.
`default_nettype none
interface sfgs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sfgs_pkg::EV_W-1:0]     event_res;
  logic                          group_dropped;
  logic [sfgs_pkg::IDX_W-1:0]    frame_index;
  logic [sfgs_pkg::DATA_W-1:0]   out_miso;
  logic [sfgs_pkg::DATA_W-1:0]   out_mosi;
  logic                          last;

  modport source (output valid, output event_res, output group_dropped,
                  output frame_index, output out_miso, output out_mosi,
                  output last, input ready);
  modport sink   (input valid, input event_res, input group_dropped,
                  input frame_index, input out_miso, input out_mosi,
                  input last, output ready);
endinterface
`default_nettype wire

@@ src/spi_frame_group_sync_debounce_unit.sv @@
// Top level: SPI frame group sync and debounce unit.
//
//  channel  | dir | handshake     | beat payload
//  in_bus   | in  | valid / ready | transfer_bits, frame_miso, frame_mosi
//  out_bus  | out | valid / ready | event_res, group_dropped, frame_index,
//           |     |               | out_miso, out_mosi, last
//  cfg_*    | in  | cfg_we        | cfg_index, cfg_wdata (no read-back)
//
// Beat taken in idle, evaluated next cycle; status-only beats then go out via emit.
// A complete passing group is copied into history frame by frame, then
// (history full) checks every slot up to any mismatch, then publishes per frame.
// Single output register: one more beat is taken while a result waits on
// out_bus, then in_bus stalls until that result leaves; no input during publish.
// Synchronous active-low reset; memories are not cleared (no clearing pass).
`default_nettype none
module spi_frame_group_sync_debounce_unit #(
  parameter int G = sfgs_pkg::GROUP_SIZE,
  parameter int S = sfgs_pkg::DEBOUNCE_SLOTS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  sfgs_in_if.sink                              in_bus,
  sfgs_out_if.source                           out_bus,
  input  wire logic                            cfg_we,
  input  wire logic [sfgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sfgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  sfgs_pkg::cmd_t cmd;
  sfgs_pkg::sts_t sts;
  logic           in_ready;

  assign in_bus.ready = in_ready;

  sfgs_ctrl #(.G(G), .S(S)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfgs_dp #(.G(G), .S(S)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_bits   (in_bus.transfer_bits),
    .in_miso   (in_bus.frame_miso),
    .in_mosi   (in_bus.frame_mosi),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_event (out_bus.event_res),
    .out_drop  (out_bus.group_dropped),
    .out_idx   (out_bus.frame_index),
    .out_miso  (out_bus.out_miso),
    .out_mosi  (out_bus.out_mosi),
    .out_last  (out_bus.last)
  );

endmodule
`default_nettype wire

@@ src/sfgs_dp.sv @@
// Datapath: config registers, beat capture, group/history memories, output register.
`default_nettype none
module sfgs_dp #(
  parameter int G = sfgs_pkg::GROUP_SIZE,
  parameter int S = sfgs_pkg::DEBOUNCE_SLOTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [sfgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfgs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [sfgs_pkg::BITS_W-1:0]       in_bits,
  input  wire logic [sfgs_pkg::DATA_W-1:0]       in_miso,
  input  wire logic [sfgs_pkg::DATA_W-1:0]       in_mosi,
  input  wire sfgs_pkg::cmd_t                    cmd,
  output sfgs_pkg::sts_t                         sts,
  input  wire logic                              out_ready,
  output logic                                   out_valid,
  output logic [sfgs_pkg::EV_W-1:0]              out_event,
  output logic                                   out_drop,
  output logic [sfgs_pkg::IDX_W-1:0]             out_idx,
  output logic [sfgs_pkg::DATA_W-1:0]            out_miso,
  output logic [sfgs_pkg::DATA_W-1:0]            out_mosi,
  output logic                                   out_last
);

  localparam int GI_W   = $clog2(G);
  localparam int HDEPTH = G * S;
  localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

  logic [sfgs_pkg::BITS_W-1:0]  exp_bits_r;
  logic [sfgs_pkg::UPPER_W-1:0] marker_r;
  logic [sfgs_pkg::BITS_W-1:0]  bits_r;
  sfgs_pkg::frame_t             beat_r;
  sfgs_pkg::frame_t             grp_mem [G];
  sfgs_pkg::frame_t             hist_mem [HDEPTH];
  sfgs_pkg::frame_t             grp_rd_r;
  sfgs_pkg::frame_t             hist_rd_r;
  logic                         out_valid_r;
  logic [sfgs_pkg::EV_W-1:0]    out_event_r;
  logic                         out_drop_r;
  logic [sfgs_pkg::IDX_W-1:0]   out_idx_r;
  sfgs_pkg::frame_t             out_data_r;
  logic                         out_last_r;

  logic [GI_W-1:0]                grp_addr;
  logic [HA_W-1:0]                hist_addr;
  logic [sfgs_pkg::UPPER_W-1:0]   upper;

  assign grp_addr  = cmd.idx[GI_W-1:0];
  assign hist_addr = HA_W'(int'(cmd.slot) * G + int'(cmd.idx));
  assign upper     = beat_r.miso[sfgs_pkg::DATA_W-1:sfgs_pkg::UPPER_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_bits_r <= sfgs_pkg::EXP_BITS_RST;
      marker_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfgs_pkg::CFG_EXPECTED_BITS: exp_bits_r <= cfg_wdata[sfgs_pkg::BITS_W-1:0];
        sfgs_pkg::CFG_MARKER_UPPER:  marker_r   <= cfg_wdata[sfgs_pkg::UPPER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      bits_r      <= in_bits;
      beat_r.miso <= in_miso;
      beat_r.mosi <= in_mosi;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grp_we) grp_mem[grp_addr] <= beat_r;
    if (cmd.grp_re) grp_rd_r <= grp_mem[grp_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_we) hist_mem[hist_addr] <= grp_rd_r;
    if (cmd.hist_re) hist_rd_r <= hist_mem[hist_addr];
  end

  always_comb begin
    sts.wrong_len = (bits_r != exp_bits_r);
    sts.empty     = (bits_r == '0);
    sts.short_len = (bits_r < exp_bits_r);
    sts.marker    = (upper == marker_r);
    sts.rep_ok    = (upper == {4{upper[7:0]}});
    sts.mismatch  = (grp_rd_r != hist_rd_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_event_r <= cmd.ev;
      out_drop_r  <= cmd.drop;
      out_last_r  <= cmd.last;
      out_idx_r   <= cmd.frame_sel ? cmd.idx : '0;
      out_data_r  <= cmd.frame_sel ? grp_rd_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event = out_event_r;
  assign out_drop  = out_drop_r;
  assign out_idx   = out_idx_r;
  assign out_miso  = out_data_r.miso;
  assign out_mosi  = out_data_r.mosi;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

@@ src/sfgs_ctrl.sv @@
// Controller: group sync state, history ring bookkeeping and sequencing FSM.
`default_nettype none
module sfgs_ctrl #(
  parameter int G = sfgs_pkg::GROUP_SIZE,
  parameter int S = sfgs_pkg::DEBOUNCE_SLOTS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire sfgs_pkg::sts_t sts,
  output sfgs_pkg::cmd_t      cmd
);

  localparam int GI_W = $clog2(G);
  localparam int PW   = sfgs_pkg::IDX_W;
  localparam int SW   = sfgs_pkg::SLOT_W;

  localparam logic [GI_W-1:0] I_LAST = GI_W'(G - 1);
  localparam logic [PW:0]     G_V    = (PW + 1)'(G);
  localparam logic [SW-1:0]   S_V    = SW'(S);
  localparam logic [SW-1:0]   S_LAST = SW'(S - 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_EVAL     = 4'd1;
  localparam logic [3:0] ST_EMIT     = 4'd2;
  localparam logic [3:0] ST_COPY_RD  = 4'd3;
  localparam logic [3:0] ST_COPY_WR  = 4'd4;
  localparam logic [3:0] ST_CMP_RD   = 4'd5;
  localparam logic [3:0] ST_CMP_CHK  = 4'd6;
  localparam logic [3:0] ST_PUB_STAT = 4'd7;
  localparam logic [3:0] ST_PUB_RD   = 4'd8;
  localparam logic [3:0] ST_PUB_LD   = 4'd9;

  logic [3:0]                 state_r, state_nxt;
  logic                       synced_r, synced_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [SW-1:0]              wslot_r, wslot_nxt;
  logic [SW-1:0]              fill_r, fill_nxt;
  logic [SW-1:0]              cur_slot_r, cur_slot_nxt;
  logic                       plaus_r, plaus_nxt;
  logic [GI_W-1:0]            i_r, i_nxt;
  logic [SW-1:0]              d_r, d_nxt;
  logic [sfgs_pkg::EV_W-1:0]  ev_r, ev_nxt;
  logic                       drop_r, drop_nxt;

  logic          partial;
  logic [PW:0]   pos_inc;
  logic [SW-1:0] slot;

  assign in_ready = (state_r == ST_IDLE);
  assign partial  = synced_r && (pos_r != '0);
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  assign slot     = (wslot_r >= S_V) ? '0 : wslot_r;

  always_comb begin
    state_nxt    = state_r;
    synced_nxt   = synced_r;
    pos_nxt      = pos_r;
    wslot_nxt    = wslot_r;
    fill_nxt     = fill_r;
    cur_slot_nxt = cur_slot_r;
    plaus_nxt    = plaus_r;
    i_nxt        = i_r;
    d_nxt        = d_r;
    ev_nxt       = ev_r;
    drop_nxt     = drop_r;
    cmd          = '0;
    cmd.cap      = in_valid && in_ready;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        drop_nxt  = 1'b0;
        state_nxt = ST_EMIT;
        if (sts.wrong_len) begin
          ev_nxt   = sts.empty ? sfgs_pkg::EV_EMPTY :
                     (sts.short_len ? sfgs_pkg::EV_SHORT : sfgs_pkg::EV_LONG);
          drop_nxt = partial;
          if (partial) begin
            pos_nxt    = '0;
            synced_nxt = 1'b0;
            fill_nxt   = '0;
          end
        end else if (sts.marker) begin
          if (partial) fill_nxt = '0;
          drop_nxt   = partial;
          synced_nxt = 1'b1;
          pos_nxt    = PW'(1);
          plaus_nxt  = sts.rep_ok;
          cmd.grp_we = 1'b1;
          cmd.idx    = '0;
          ev_nxt     = sfgs_pkg::EV_STARTED;
        end else if (!partial) begin
          ev_nxt = sfgs_pkg::EV_IGNORED;
        end else begin
          cmd.grp_we = 1'b1;
          cmd.idx    = pos_r;
          if (pos_inc < G_V) begin
            pos_nxt   = pos_inc[PW-1:0];
            plaus_nxt = plaus_r && sts.rep_ok;
            ev_nxt    = sfgs_pkg::EV_STORED;
          end else begin
            pos_nxt = '0;
            if (!(plaus_r && sts.rep_ok)) begin
              ev_nxt = sfgs_pkg::EV_CHKFAIL;
            end else begin
              cur_slot_nxt = slot;
              wslot_nxt    = (slot == S_LAST) ? '0 : slot + 1'b1;
              if (fill_r < S_V) fill_nxt = fill_r + 1'b1;
              i_nxt     = '0;
              state_nxt = ST_COPY_RD;
            end
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ev       = ev_r;
          cmd.drop     = drop_r;
          cmd.last     = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_COPY_RD: begin
        cmd.grp_re = 1'b1;
        cmd.idx    = PW'(i_r);
        state_nxt  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.hist_we = 1'b1;
        cmd.idx     = PW'(i_r);
        cmd.slot    = cur_slot_r;
        if (i_r == I_LAST) begin
          i_nxt = '0;
          d_nxt = '0;
          if (fill_r == S_V) begin
            state_nxt = ST_CMP_RD;
          end else begin
            ev_nxt    = sfgs_pkg::EV_AWAITING;
            state_nxt = ST_EMIT;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = ST_COPY_RD;
        end
      end
      ST_CMP_RD: begin
        cmd.grp_re  = 1'b1;
        cmd.hist_re = 1'b1;
        cmd.idx     = PW'(i_r);
        cmd.slot    = d_r;
        state_nxt   = ST_CMP_CHK;
      end
      ST_CMP_CHK: begin
        if (sts.mismatch) begin
          ev_nxt    = sfgs_pkg::EV_AWAITING;
          state_nxt = ST_EMIT;
        end else if (d_r == S_LAST) begin
          d_nxt = '0;
          if (i_r == I_LAST) begin
            i_nxt     = '0;
            state_nxt = ST_PUB_STAT;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_CMP_RD;
          end
        end else begin
          d_nxt     = d_r + 1'b1;
          state_nxt = ST_CMP_RD;
        end
      end
      ST_PUB_STAT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ev       = sfgs_pkg::EV_PUBLISHED;
          state_nxt    = ST_PUB_RD;
        end
      end
      ST_PUB_RD: begin
        cmd.grp_re = 1'b1;
        cmd.idx    = PW'(i_r);
        state_nxt  = ST_PUB_LD;
      end
      ST_PUB_LD: begin
        cmd.idx = PW'(i_r);
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.ev        = sfgs_pkg::EV_FRAME;
          cmd.frame_sel = 1'b1;
          cmd.last      = (i_r == I_LAST);
          if (i_r == I_LAST) begin
            i_nxt     = '0;
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = ST_PUB_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      synced_r   <= 1'b0;
      pos_r      <= '0;
      wslot_r    <= '0;
      fill_r     <= '0;
      cur_slot_r <= '0;
      plaus_r    <= 1'b0;
      i_r        <= '0;
      d_r        <= '0;
      ev_r       <= sfgs_pkg::EV_EMPTY;
      drop_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      synced_r   <= synced_nxt;
      pos_r      <= pos_nxt;
      wslot_r    <= wslot_nxt;
      fill_r     <= fill_nxt;
      cur_slot_r <= cur_slot_nxt;
      plaus_r    <= plaus_nxt;
      i_r        <= i_nxt;
      d_r        <= d_nxt;
      ev_r       <= ev_nxt;
      drop_r     <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/sfgs_chk.sv @@
// Port-level checker for the sync/debounce unit and its bind.
`default_nettype none
module sfgs_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sfgs_pkg::EV_W-1:0]     event_res,
  input wire logic                          group_dropped,
  input wire logic [sfgs_pkg::IDX_W-1:0]    frame_index,
  input wire logic [sfgs_pkg::DATA_W-1:0]   out_miso,
  input wire logic [sfgs_pkg::DATA_W-1:0]   out_mosi,
  input wire logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) &&
      $stable(out_miso) && $stable(out_mosi) && $stable(last))
    else $error("result beat changed while stalled");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != sfgs_pkg::EV_PUBLISHED &&
      event_res != sfgs_pkg::EV_FRAME |-> last)
    else $error("status beat without last");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res != sfgs_pkg::EV_FRAME |->
      out_miso == '0 && out_mosi == '0 && frame_index == '0)
    else $error("status beat carries frame data");

  a_frame_nodrop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == sfgs_pkg::EV_FRAME |-> !group_dropped)
    else $error("frame beat flags a dropped group");

  a_pub_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_res == sfgs_pkg::EV_PUBLISHED |-> !(in_valid && in_ready))
    else $error("input taken during publish");

endmodule

bind spi_frame_group_sync_debounce_unit sfgs_chk u_sfgs_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .event_res     (out_bus.event_res),
  .group_dropped (out_bus.group_dropped),
  .frame_index   (out_bus.frame_index),
  .out_miso      (out_bus.out_miso),
  .out_mosi      (out_bus.out_mosi),
  .last          (out_bus.last)
);
`default_nettype wire
